// ===== src/rtfh_pkg.sv =====
`default_nettype none
package rtfh_pkg;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    localparam logic [7:0] C_BSL = 8'h5C;
    localparam logic [7:0] C_P   = 8'h70;
    localparam logic [7:0] C_A   = 8'h61;
    localparam logic [7:0] C_R   = 8'h72;
    localparam logic [7:0] C_D   = 8'h64;
    localparam logic [7:0] C_Q   = 8'h71;
    localparam logic [7:0] C_C   = 8'h63;
    localparam logic [7:0] C_SP  = 8'h20;
    localparam logic [7:0] C_NL  = 8'h0A;

    localparam logic [71:0] S_CLOSE = "</CENTER>";
    localparam logic [71:0] S_OPEN  = "<CENTER>";
    localparam logic [71:0] S_BR    = "<br>\n";

    typedef enum logic [2:0] {
        K_COPY,
        K_END,
        K_BR,
        K_OPEN,
        K_CLOSE
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] ch;
    } t_tok;

    function automatic logic [3:0] str_len(input t_kind k);
        case (k)
            K_CLOSE: return 4'd9;
            K_OPEN:  return 4'd8;
            K_BR:    return 4'd5;
            default: return 4'd1;
        endcase
    endfunction

    function automatic logic [7:0] str_char(input t_kind k, input logic [3:0] idx);
        logic [71:0] s;
        logic [3:0]  rem;
        case (k)
            K_CLOSE: s = S_CLOSE;
            K_OPEN:  s = S_OPEN;
            K_BR:    s = S_BR;
            default: s = '0;
        endcase
        rem = str_len(k) - 4'd1 - idx;
        return s[{rem, 3'b000} +: 8];
    endfunction

endpackage
`default_nettype wire

// ===== src/rtfh_fifo.sv =====
`default_nettype none
module rtfh_fifo (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_wr,
    input  rtfh_pkg::t_tok    i_wr_tok,
    output logic              o_full,
    input  wire               i_rd,
    output rtfh_pkg::t_tok    o_rd_tok,
    output logic              o_empty
);
    import rtfh_pkg::*;

    t_tok            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wp, r_rp;
    logic [Q_AW:0]   r_cnt;

    assign o_full   = (r_cnt == (Q_AW+1)'(Q_DEPTH));
    assign o_empty  = (r_cnt == '0);
    assign o_rd_tok = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wp] <= i_wr_tok;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_wr) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_rd) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({i_wr, i_rd})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== src/rtfh_front.sv =====
`default_nettype none
module rtfh_front (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_push,
    output logic              o_full,
    input  wire  [7:0]        i_in_byte,
    input  wire               i_is_final,
    input  wire               i_q_full,
    output logic              o_q_wr,
    output rtfh_pkg::t_tok    o_q_tok
);
    import rtfh_pkg::*;

    logic [7:0] r_win [5];
    logic [2:0] r_cnt;
    logic [2:0] r_skip;
    logic       r_ctr;
    logic       r_flush;

    logic [7:0] dw [5];
    logic       accept, do_dec, end_emit;
    logic       tv, n_ctr;
    logic [2:0] n_skip;
    t_tok       tk;

    assign o_full   = r_flush || i_q_full;
    assign accept   = i_push && !o_full;
    assign do_dec   = (accept && !i_is_final && r_cnt == 3'd4)
                   || (r_flush && !i_q_full && r_cnt != 3'd0);
    assign end_emit = r_flush && !i_q_full && r_cnt == 3'd0;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            dw[i] = r_win[i];
        end
        dw[4] = r_flush ? r_win[4] : i_in_byte;
    end

    // head decision: command match against the five-byte window
    always_comb begin
        tv      = 1'b0;
        tk.kind = K_COPY;
        tk.ch   = dw[0];
        n_skip  = r_skip;
        n_ctr   = r_ctr;
        if (r_skip != 3'd0) begin
            n_skip = r_skip - 3'd1;
        end else if (dw[0] == C_BSL && dw[1] == C_P && dw[2] == C_A
                     && dw[3] == C_R && dw[4] == C_D) begin
            n_skip = 3'd4;
            if (r_ctr) begin
                tv      = 1'b1;
                tk.kind = K_CLOSE;
                n_ctr   = 1'b0;
            end
        end else if (dw[0] == C_BSL && dw[1] == C_P && dw[2] == C_A && dw[3] == C_R) begin
            n_skip  = 3'd3;
            tv      = 1'b1;
            tk.kind = K_BR;
        end else if (dw[0] == C_BSL && (dw[1] == C_SP || dw[1] == C_NL)) begin
            n_skip = 3'd1;
        end else if (dw[0] == C_BSL && dw[1] == C_Q && dw[2] == C_C) begin
            n_skip = 3'd2;
            if (!r_ctr) begin
                tv      = 1'b1;
                tk.kind = K_OPEN;
                n_ctr   = 1'b1;
            end
        end else begin
            tv = 1'b1;
        end
    end

    always_comb begin
        o_q_wr = (do_dec && tv) || end_emit;
        if (end_emit) begin
            o_q_tok.kind = K_END;
            o_q_tok.ch   = 8'h00;
        end else begin
            o_q_tok = tk;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || end_emit) begin
            for (int i = 0; i < 5; i++) begin
                r_win[i] <= 8'h00;
            end
            r_cnt   <= '0;
            r_skip  <= '0;
            r_ctr   <= 1'b0;
            r_flush <= 1'b0;
        end else if (r_flush) begin
            if (do_dec) begin
                for (int i = 0; i < 4; i++) begin
                    r_win[i] <= r_win[i+1];
                end
                r_win[4] <= 8'h00;
                r_cnt    <= r_cnt - 3'd1;
                r_skip   <= n_skip;
                r_ctr    <= n_ctr;
            end
        end else if (accept) begin
            if (i_is_final || r_cnt != 3'd4) begin
                r_win[r_cnt] <= i_in_byte;
                r_cnt        <= r_cnt + 3'd1;
                r_flush      <= i_is_final;
            end else begin
                for (int i = 0; i < 3; i++) begin
                    r_win[i] <= r_win[i+1];
                end
                r_win[3] <= i_in_byte;
                r_skip   <= n_skip;
                r_ctr    <= n_ctr;
            end
        end
    end
endmodule
`default_nettype wire

// ===== src/rtfh_back.sv =====
`default_nettype none
module rtfh_back (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  rtfh_pkg::t_tok    i_q_tok,
    input  wire               i_q_empty,
    output logic              o_q_rd,
    output logic              o_empty,
    input  wire               i_pop,
    output logic [7:0]        o_out_byte,
    output logic              o_end_of_text
);
    import rtfh_pkg::*;

    logic       r_act;
    t_kind      r_kind;
    logic [3:0] r_idx;
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_end;

    logic adv;

    assign o_empty       = !r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_end_of_text = r_out_end;
    assign adv           = !r_out_valid || i_pop;
    assign o_q_rd        = adv && !r_act && !i_q_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act       <= 1'b0;
            r_kind      <= K_COPY;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
            r_out_byte  <= 8'h00;
            r_out_end   <= 1'b0;
        end else if (adv) begin
            if (r_act) begin
                r_out_valid <= 1'b1;
                r_out_byte  <= str_char(r_kind, r_idx);
                r_out_end   <= 1'b0;
                r_idx       <= r_idx + 4'd1;
                r_act       <= (r_idx != str_len(r_kind) - 4'd1);
            end else if (!i_q_empty) begin
                r_out_valid <= 1'b1;
                r_out_end   <= (i_q_tok.kind == K_END);
                case (i_q_tok.kind)
                    K_COPY, K_END: begin
                        r_out_byte <= i_q_tok.ch;
                    end
                    default: begin
                        r_out_byte <= str_char(i_q_tok.kind, 4'd0);
                        r_kind     <= i_q_tok.kind;
                        r_idx      <= 4'd1;
                        r_act      <= 1'b1;
                    end
                endcase
            end else begin
                r_out_valid <= 1'b0;
            end
        end
    end
endmodule
`default_nettype wire

// ===== src/rtf_subset_to_html_stream_core.sv =====
// After the decision on a byte, its token is written to the token queue; its first
// output byte is then registered in the output stage. A byte is decided once four
// later bytes or the final one have arrived. Throughput: 1 byte per cycle in and out
// for plain text while the queue has room and output is popped; each tag's string is
// sent one byte at a time. A final transaction stalls input while held bytes flush.
// Reset (synchronous, active low) empties the queue and clears window and flag.
`default_nettype none
module rtf_subset_to_html_stream_core (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        push,
    output logic       full,
    input  wire  [7:0] i_in_byte,
    input  wire        i_is_final,
    output logic       empty,
    input  wire        pop,
    output logic [7:0] o_out_byte,
    output logic       o_end_of_text
);
    import rtfh_pkg::*;

    logic q_wr, q_full, q_rd, q_empty;
    t_tok q_wr_tok, q_rd_tok;

    rtfh_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_full     (full),
        .i_in_byte  (i_in_byte),
        .i_is_final (i_is_final),
        .i_q_full   (q_full),
        .o_q_wr     (q_wr),
        .o_q_tok    (q_wr_tok)
    );

    rtfh_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (q_wr),
        .i_wr_tok (q_wr_tok),
        .o_full   (q_full),
        .i_rd     (q_rd),
        .o_rd_tok (q_rd_tok),
        .o_empty  (q_empty)
    );

    rtfh_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_tok       (q_rd_tok),
        .i_q_empty     (q_empty),
        .o_q_rd        (q_rd),
        .o_empty       (empty),
        .i_pop         (pop),
        .o_out_byte    (o_out_byte),
        .o_end_of_text (o_end_of_text)
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_wr && q_full))
        else $error("token queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_rd && q_empty))
        else $error("token queue read while empty");

    a_end_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_end_of_text) |-> (o_out_byte == 8'h00))
        else $error("terminator byte is not zero");

endmodule
`default_nettype wire
